>>> hw/rtl/subscription_match_table_assert.svh
// Assertion macros for the subscription match table.
`ifndef SUBSCRIPTION_MATCH_TABLE_ASSERT_SVH
`define SUBSCRIPTION_MATCH_TABLE_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define SMT_ASSERT_NOW(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// Condition implies consequence in the next cycle.
`define SMT_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/smt_pkg.sv
// ----------------------------------------------------------------------------
// smt_pkg
// Shared constants and types of the subscription match table.
// ----------------------------------------------------------------------------
package smt_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int ID_WIDTH    = 16;
	localparam int REC_W       = 4 * ID_WIDTH;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	localparam logic [2:0] STS_ADDED    = 3'd0;
	localparam logic [2:0] STS_DUP      = 3'd1;
	localparam logic [2:0] STS_FULL     = 3'd2;
	localparam logic [2:0] STS_REMOVED  = 3'd3;
	localparam logic [2:0] STS_NOTFOUND = 3'd4;
	localparam logic [2:0] STS_MATCH    = 3'd5;

	typedef logic [REC_W-1:0] rec_t;

	typedef struct packed {
		logic load_new;
		logic load_left;
		logic load_right;
	} cell_ctl_t;

	typedef struct packed {
		logic eq;
		logic key;
		logic lt;
	} cell_stat_t;

endpackage

>>> hw/rtl/smt_cell.sv
// ----------------------------------------------------------------------------
// smt_cell
// One table slot: holds a record, compares it against the request and takes
// a new record, or the record of its left or right neighbor.
// ----------------------------------------------------------------------------
module smt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  smt_pkg::cell_ctl_t  ctl,
	input  smt_pkg::rec_t       new_rec,
	input  logic                left_valid,
	input  smt_pkg::rec_t       left_rec,
	input  logic                right_valid,
	input  smt_pkg::rec_t       right_rec,
	output logic                valid,
	output smt_pkg::rec_t       rec,
	output smt_pkg::cell_stat_t stat
);

	logic          valid_q;
	smt_pkg::rec_t rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load_new) begin
			valid_q <= 1'b1;
		end else if (ctl.load_left) begin
			valid_q <= left_valid;
		end else if (ctl.load_right) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_new) begin
			rec_q <= new_rec;
		end else if (ctl.load_left) begin
			rec_q <= left_rec;
		end else if (ctl.load_right) begin
			rec_q <= right_rec;
		end
	end

	assign valid     = valid_q;
	assign rec       = rec_q;
	assign stat.eq   = valid_q && (rec_q == new_rec);
	assign stat.key  = valid_q &&
		(rec_q[3*smt_pkg::ID_WIDTH-1:0] == new_rec[3*smt_pkg::ID_WIDTH-1:0]);
	assign stat.lt   = valid_q &&
		(rec_q[smt_pkg::REC_W-1 -: smt_pkg::ID_WIDTH] <
		 new_rec[smt_pkg::REC_W-1 -: smt_pkg::ID_WIDTH]);

endmodule

>>> hw/rtl/subscription_match_table.sv
// ----------------------------------------------------------------------------
// subscription_match_table
// Table of unique subscriptions kept as a chain of cells sorted by node.
// ----------------------------------------------------------------------------
// Channel | Handshake            | Payload
// in      | in_valid / in_stall  | cmd, subscriber_node, class_key, instance_key,
//         |                      | attribute_key
// out     | out_valid / out_stall| status, matched_node, last_result, entry_count
//
// Add, remove, unused commands and lookups without hits pass capture, compare
// and execute. A lookup with hits then scans the cells in order, one cell per
// cycle while the output is not stalled, up to the last matching one, and gives
// one result per match. Entries stay packed at the low cells in ascending node
// order, so inserts shift the chain right and removes shift it left in execute.
// Reset empties the table at once. Output stall holds the sequencer.
// ----------------------------------------------------------------------------
module subscription_match_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [15:0] subscriber_node,
	input  logic [15:0] class_key,
	input  logic [15:0] instance_key,
	input  logic [15:0] attribute_key,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] matched_node,
	output logic        last_result,
	output logic [5:0]  entry_count
);

	localparam int D  = smt_pkg::TABLE_DEPTH;
	localparam int IW = smt_pkg::ID_WIDTH;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;
	localparam logic [1:0] ST_SCAN = 2'd3;

	logic [1:0]                state_q;
	logic [1:0]                cmd_q;
	smt_pkg::rec_t             req_q;
	logic [D-1:0]              eq_q, key_q, lt_q, hit_q;
	logic [smt_pkg::IDX_W-1:0] ptr_q;
	logic [smt_pkg::CNT_W-1:0] count_q;

	logic                      out_valid_q, last_q;
	logic [2:0]                status_q;
	logic [15:0]               node_q;
	logic [5:0]                count_out_q;

	logic [D-1:0]              valid_v, eq_v, key_v, lt_v, pre_v;
	smt_pkg::rec_t             rec_v [D];
	smt_pkg::cell_ctl_t        ctl_v [D];
	smt_pkg::cell_stat_t       stat_v [D];

	logic                      out_free, do_exec, ins, rem, scan_last, emit;
	logic [D-1:0]              sel;
	logic [smt_pkg::CNT_W-1:0] count_nx;

	assign out_free = !out_valid_q || !out_stall;
	assign do_exec  = (state_q == ST_EXEC) && out_free;
	assign ins = do_exec && (cmd_q == smt_pkg::CMD_ADD) && !(|eq_q) &&
		(count_q != smt_pkg::CNT_W'(D));
	assign rem = do_exec && (cmd_q == smt_pkg::CMD_REMOVE) && (|eq_q);
	// eq_q is one-hot when set: every cell at or above the hit pulls from the right
	assign pre_v = rem ? ~(eq_q - D'(1)) : '0;

	assign sel       = D'(1) << ptr_q;
	assign scan_last = (hit_q & ~sel) == '0;

	assign count_nx = ins ? count_q + 1'b1 : (rem ? count_q - 1'b1 : count_q);

	// a result goes out on every execute but a lookup with hits, and on each scan hit
	assign emit = (do_exec && !(cmd_q == smt_pkg::CMD_LOOKUP && (|key_q))) ||
		((state_q == ST_SCAN) && out_free && (|(hit_q & sel)));

	for (genvar i = 0; i < D; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign ctl_v[i].load_new  = ins && !lt_q[i];
			assign ctl_v[i].load_left = 1'b0;
		end else begin : g_rest
			assign ctl_v[i].load_new  = ins && !lt_q[i] && lt_q[i-1];
			assign ctl_v[i].load_left = ins && !lt_q[i] && !lt_q[i-1];
		end
		assign ctl_v[i].load_right = pre_v[i];

		smt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl_v[i]),
			.new_rec    (req_q),
			.left_valid ((i == 0) ? 1'b0 : valid_v[(i == 0) ? 0 : i-1]),
			.left_rec   (rec_v[(i == 0) ? 0 : i-1]),
			.right_valid((i == D-1) ? 1'b0 : valid_v[(i == D-1) ? i : i+1]),
			.right_rec  (rec_v[(i == D-1) ? i : i+1]),
			.valid      (valid_v[i]),
			.rec        (rec_v[i]),
			.stat       (stat_v[i])
		);

		assign eq_v[i]  = stat_v[i].eq;
		assign key_v[i] = stat_v[i].key;
		assign lt_v[i]  = stat_v[i].lt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit || (out_valid_q && out_stall);
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (out_free) begin
						if (cmd_q == smt_pkg::CMD_LOOKUP && (|key_q)) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_IDLE;
						end
						if (ins) begin
							count_q <= count_q + 1'b1;
						end
						if (rem) begin
							count_q <= count_q - 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (out_free && (|(hit_q & sel))) begin
						if (scan_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd_q <= cmd;
					req_q <= {subscriber_node[IW-1:0], class_key[IW-1:0],
						instance_key[IW-1:0], attribute_key[IW-1:0]};
				end
			end
			ST_CMP: begin
				eq_q  <= eq_v;
				key_q <= key_v;
				lt_q  <= lt_v;
			end
			ST_EXEC: begin
				if (out_free) begin
					hit_q       <= key_q;
					ptr_q       <= '0;
					node_q      <= '0;
					last_q      <= 1'b1;
					count_out_q <= 6'(count_nx);
					case (cmd_q)
						smt_pkg::CMD_ADD: begin
							if (|eq_q) begin
								status_q <= smt_pkg::STS_DUP;
							end else if (count_q == smt_pkg::CNT_W'(D)) begin
								status_q <= smt_pkg::STS_FULL;
							end else begin
								status_q <= smt_pkg::STS_ADDED;
							end
						end
						smt_pkg::CMD_REMOVE: begin
							if (|eq_q) begin
								status_q <= smt_pkg::STS_REMOVED;
							end else begin
								status_q <= smt_pkg::STS_NOTFOUND;
							end
						end
						default: status_q <= smt_pkg::STS_NOTFOUND;
					endcase
				end
			end
			ST_SCAN: begin
				if (out_free) begin
					ptr_q <= ptr_q + 1'b1;
					if (|(hit_q & sel)) begin
						hit_q       <= hit_q & ~sel;
						status_q    <= smt_pkg::STS_MATCH;
						node_q      <= 16'(rec_v[ptr_q][smt_pkg::REC_W-1 -: IW]);
						last_q      <= scan_last;
						count_out_q <= 6'(count_q);
					end
				end
			end
			default: ;
		endcase
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign matched_node = node_q;
	assign last_result  = last_q;
	assign entry_count  = count_out_q;

`include "subscription_match_table_assert.svh"

	`SMT_ASSERT_NOW(a_count_range, 1'b1, count_q <= smt_pkg::CNT_W'(D), "count above depth")
	`SMT_ASSERT_NOW(a_packed, 1'b1, (valid_v & (valid_v + D'(1))) == '0, "entries not packed")
	`SMT_ASSERT_NOW(a_scan_hits, state_q == ST_SCAN, hit_q != '0, "scan with no hits left")
	`SMT_ASSERT_NOW(a_unique, state_q == ST_EXEC, $onehot0(eq_q), "duplicate entries")
	`SMT_ASSERT_NEXT(a_ins_count, ins, count_q == $past(count_q) + 1'b1, "insert count")

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the subscription match table: a directed table of
// adds, removes and lookups, then random traffic over a small key space,
// checked against a behavioral model of the table, randomly idling in the first two phases.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_REQS = 99;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [2:0]  status;
		logic [15:0] node;
		logic        last;
		logic [5:0]  count;
	} resp_t;

	typedef struct {
		logic [1:0]  op;
		logic [15:0] node;
		logic [15:0] cls;
		logic [15:0] inst;
		logic [15:0] attr;
		logic        known;   // expected status and count typed in below
		logic [2:0]  status;
		logic [5:0]  count;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  cmd;
	logic [15:0] subscriber_node;
	logic [15:0] class_key;
	logic [15:0] instance_key;
	logic [15:0] attribute_key;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [15:0] matched_node;
	logic        last_result;
	logic [5:0]  entry_count;

	subscription_match_table dut (.*);

	// table image
	logic        sub_valid [smt_pkg::TABLE_DEPTH];
	logic [63:0] sub_rec [smt_pkg::TABLE_DEPTH];
	int          sub_count;

	resp_t pending_resp[$];
	row_t  dir_rows[$];
	int    errors;
	int    cycles;
	int    n_resp;
	int    n_match;
	int    send_idle_pct;
	int    recv_idle_pct;
	bit    hold_off;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic report(input string what, input int got, input int want);
		errors++;
		$display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
	endtask

	function automatic void push_resp(logic [2:0] s, logic [15:0] n, logic l);
		resp_t r;
		r.status = s;
		r.node = n;
		r.last = l;
		r.count = sub_count[5:0];
		pending_resp = {pending_resp, r};
	endfunction

	function automatic void queue_row(row_t r);
		dir_rows = {dir_rows, r};
	endfunction

	// updates the table image and queues the expected responses
	function automatic void predict_table(logic [1:0] op, logic [15:0] nd, logic [15:0] c,
			logic [15:0] i, logic [15:0] a);
		logic [63:0] rec;
		logic [15:0] hits[$];
		int hit;
		hit = -1;
		rec = {nd, c, i, a};
		for (int k = 0; k < smt_pkg::TABLE_DEPTH; k++)
			if (sub_valid[k] && sub_rec[k] == rec)
				hit = k;
		case (op)
			smt_pkg::CMD_ADD: begin
				if (hit >= 0) begin
					push_resp(smt_pkg::STS_DUP, '0, 1'b1);
				end else begin
					for (int k = 0; k < smt_pkg::TABLE_DEPTH; k++)
						if (!sub_valid[k] && hit < 0) begin
							hit = k;
							sub_valid[k] = 1'b1;
							sub_rec[k] = rec;
							sub_count++;
						end
					push_resp(hit >= 0 ? smt_pkg::STS_ADDED : smt_pkg::STS_FULL, '0, 1'b1);
				end
			end
			smt_pkg::CMD_REMOVE: begin
				if (hit >= 0) begin
					sub_valid[hit] = 1'b0;
					sub_count--;
					push_resp(smt_pkg::STS_REMOVED, '0, 1'b1);
				end else begin
					push_resp(smt_pkg::STS_NOTFOUND, '0, 1'b1);
				end
			end
			smt_pkg::CMD_LOOKUP: begin
				for (int k = 0; k < smt_pkg::TABLE_DEPTH; k++)
					if (sub_valid[k] && sub_rec[k][47:0] == {c, i, a})
						hits = {hits, sub_rec[k][63:48]};
				hits.sort();
				if (hits.size() == 0)
					push_resp(smt_pkg::STS_NOTFOUND, '0, 1'b1);
				foreach (hits[k])
					push_resp(smt_pkg::STS_MATCH, hits[k], k == hits.size() - 1);
			end
			default: push_resp(smt_pkg::STS_NOTFOUND, '0, 1'b1);
		endcase
	endfunction

	task automatic send_request(input row_t r);
		int depth;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		depth = pending_resp.size();
		predict_table(r.op, r.node, r.cls, r.inst, r.attr);
		if (r.known) begin
			if (pending_resp[depth].status != r.status)
				report("typed status", int'(pending_resp[depth].status), int'(r.status));
			if (pending_resp[depth].count != r.count)
				report("typed count", int'(pending_resp[depth].count), int'(r.count));
		end
		in_valid <= 1'b1;
		cmd <= r.op;
		subscriber_node <= r.node;
		class_key <= r.cls;
		instance_key <= r.inst;
		attribute_key <= r.attr;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1;
		end else begin
			out_stall <= hold_off || (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
		end
	end

	// response checker
	always @(posedge clk) begin
		resp_t w;
		if (arst_n && out_valid && !out_stall) begin
			n_resp++;
			if (status == smt_pkg::STS_MATCH)
				n_match++;
			if (pending_resp.size() == 0) begin
				report("unexpected response status", int'(status), 0);
			end else begin
				w = pending_resp.pop_front();
				if (status !== w.status)
					report("status", int'(status), int'(w.status));
				if (matched_node !== w.node)
					report("matched_node", int'(matched_node), int'(w.node));
				if (last_result !== w.last)
					report("last_result", int'(last_result), int'(w.last));
				if (entry_count !== w.count)
					report("entry_count", int'(entry_count), int'(w.count));
			end
		end
	end

	function automatic row_t mk(logic [1:0] op, logic [15:0] nd, logic [15:0] c,
			logic [15:0] i, logic [15:0] a);
		row_t r;
		r.op = op;
		r.node = nd;
		r.cls = c;
		r.inst = i;
		r.attr = a;
		r.known = 1'b0;
		r.status = smt_pkg::STS_ADDED;
		r.count = '0;
		return r;
	endfunction

	function automatic row_t mkk(logic [1:0] op, logic [15:0] nd, logic [15:0] c,
			logic [15:0] i, logic [15:0] a, logic [2:0] s, logic [5:0] n);
		row_t r;
		r = mk(op, nd, c, i, a);
		r.known = 1'b1;
		r.status = s;
		r.count = n;
		return r;
	endfunction

	function automatic row_t random_request(int phase);
		row_t r;
		int p;
		p = $urandom_range(99);
		// small key space so adds, removes and lookups collide often
		r = mk(p < 45 ? smt_pkg::CMD_ADD : p < 70 ? smt_pkg::CMD_REMOVE :
			p < 97 ? smt_pkg::CMD_LOOKUP : CMD_UNUSED,
			16'($urandom_range(7)), 16'($urandom_range(1)),
			16'(32'h00F0 + $urandom_range(1)), '0);
		r.attr = $urandom_range(1) ? 16'hFFFF : 16'h0000;
		if ($urandom_range(9) == 0) begin
			r.node = 16'($urandom);
			r.cls = 16'($urandom);
			r.inst = 16'($urandom);
			r.attr = 16'($urandom);
		end
		if (phase == 2 && r.op == smt_pkg::CMD_REMOVE)
			r.op = smt_pkg::CMD_ADD;
		return r;
	endfunction

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_resp.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		n_resp = 0;
		n_match = 0;
		hold_off = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		in_valid = 0;
		cmd = smt_pkg::CMD_ADD;
		subscriber_node = 0;
		class_key = 0;
		instance_key = 0;
		attribute_key = 0;
		sub_count = 0;
		foreach (sub_valid[k]) begin
			sub_valid[k] = 0;
			sub_rec[k] = 0;
		end
		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		queue_row(mkk(smt_pkg::CMD_LOOKUP, '0, '0, '0, '0, smt_pkg::STS_NOTFOUND, 6'd0));
		queue_row(mkk(smt_pkg::CMD_REMOVE, '0, '0, '0, '0, smt_pkg::STS_NOTFOUND, 6'd0));
		queue_row(mkk(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			smt_pkg::STS_NOTFOUND, 6'd0));
		queue_row(mkk(smt_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			smt_pkg::STS_ADDED, 6'd1));
		queue_row(mkk(smt_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			smt_pkg::STS_DUP, 6'd1));
		queue_row(mkk(smt_pkg::CMD_ADD, '0, '0, '0, '0, smt_pkg::STS_ADDED, 6'd2));
		queue_row(mkk(smt_pkg::CMD_ADD, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			smt_pkg::STS_ADDED, 6'd3));
		queue_row(mkk(smt_pkg::CMD_ADD, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			smt_pkg::STS_ADDED, 6'd4));
		queue_row(mk(smt_pkg::CMD_LOOKUP, 16'h1234, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		queue_row(mk(smt_pkg::CMD_LOOKUP, '0, '0, '0, '0));
		queue_row(mkk(smt_pkg::CMD_REMOVE, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			smt_pkg::STS_REMOVED, 6'd3));
		queue_row(mkk(smt_pkg::CMD_REMOVE, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			smt_pkg::STS_NOTFOUND, 6'd3));
		queue_row(mkk(smt_pkg::CMD_ADD, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
			smt_pkg::STS_ADDED, 6'd4));
		queue_row(mk(smt_pkg::CMD_LOOKUP, '0, 16'hAAAA, 16'h5555, 16'hAAAA));
		queue_row(mkk(smt_pkg::CMD_LOOKUP, '0, 16'hAAAA, 16'h5555, 16'hAAAB,
			smt_pkg::STS_NOTFOUND, 6'd4));
		// fill the table to the brim: 28 more entries on one key, descending nodes
		for (int k = 0; k < 28; k++)
			queue_row(mk(smt_pkg::CMD_ADD, 16'(100 - k), 16'h0042, '0, 16'h0042));
		queue_row(mkk(smt_pkg::CMD_ADD, 16'h0001, 16'h0001, 16'h0001, 16'h0001,
			smt_pkg::STS_FULL, 6'd32));
		queue_row(mkk(smt_pkg::CMD_ADD, '0, '0, '0, '0, smt_pkg::STS_DUP, 6'd32));
		queue_row(mk(smt_pkg::CMD_LOOKUP, '0, 16'h0042, '0, 16'h0042));
		foreach (dir_rows[k])
			send_request(dir_rows[k]);
		drain();

		// long receiver hold-off while the sender keeps feeding lookups
		hold_off <= 1;
		fork
			repeat (300) @(posedge clk);
			for (int k = 0; k < 8; k++)
				send_request(mk(smt_pkg::CMD_LOOKUP, '0, 16'h0042, '0, 16'h0042));
		join_any
		hold_off <= 0;
		wait fork;
		drain();

		// empty the full key again
		for (int k = 0; k < 28; k++)
			send_request(mk(smt_pkg::CMD_REMOVE, 16'(100 - k), 16'h0042, '0, 16'h0042));
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = phase == 0 ? 19 : phase == 1 ? 86 : 0;
			recv_idle_pct = phase == 0 ? 86 : phase == 1 ? 19 : 0;
			for (int k = 0; k < RANDOM_REQS / 3; k++)
				send_request(random_request(phase));
		end
		drain();

		$display("covered: %0d responses, %0d lookup matches, table filled and drained",
			n_resp, n_match);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
